@@ rtl/ebid_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ebid_pkg
// Shared types, constants and helpers of the ELF build-id note scanner.
// ----------------------------------------------------------------------------
package ebid_pkg;

    localparam int POSITION_BITS = 16;
    // Wide enough for a note start plus a header plus two padded 32-bit sizes.
    localparam int WIDE_BITS     = 35;
    localparam int LEN_BITS      = 16;
    localparam int PADDR_BITS    = 3;

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [WIDE_BITS-1:0]     wide_t;
    typedef logic [LEN_BITS-1:0]      len_t;

    localparam int unsigned HDR_BYTES     = 12;
    localparam int unsigned BUILD_ID_TYPE = 3;
    localparam int unsigned MIN_NAME_SIZE = 4;

    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [PADDR_BITS-1:0] ADDR_AREA_LENGTH = 3'd0;

    typedef struct packed {
        logic [7:0] id_byte;
        logic       id_byte_valid;
        logic       finished;
        logic [1:0] scan_status;
    } result_t;

    // Bytes of the owner name "GNU".
    function automatic logic [7:0] gnu_tag(input logic [1:0] idx);
        logic [7:0] tag;
        unique case (idx)
            2'd0:    tag = 8'h47;
            2'd1:    tag = 8'h4E;
            2'd2:    tag = 8'h55;
            default: tag = 8'h00;
        endcase
        return tag;
    endfunction

    // Round a 32-bit size up to a multiple of four without losing the carry.
    function automatic wide_t pad4(input logic [31:0] v);
        return (wide_t'(v) + wide_t'(3)) & ~wide_t'(3);
    endfunction

endpackage
`default_nettype wire

@@ rtl/ebid_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ebid_if
// Valid/ready channels of the scanner: area bytes in, results out.
// ----------------------------------------------------------------------------
interface ebid_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] area_byte;
    logic       area_end;

    modport source (output valid, output area_byte, output area_end, input ready);
    modport sink   (input valid, input area_byte, input area_end, output ready);
endinterface

interface ebid_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] id_byte;
    logic       id_byte_valid;
    logic       finished;
    logic [1:0] scan_status;

    modport source (output valid, output id_byte, output id_byte_valid,
                    output finished, output scan_status, input ready);
    modport sink   (input valid, input id_byte, input id_byte_valid,
                    input finished, input scan_status, output ready);
endinterface
`default_nettype wire

@@ rtl/ebid_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ebid_cfg
// APB register file holding the note area length.
// ----------------------------------------------------------------------------
module ebid_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ebid_pkg::PADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready,
    output ebid_pkg::len_t                      area_length
);

    ebid_pkg::len_t area_length_reg;
    ebid_pkg::len_t area_length_next;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == ebid_pkg::ADDR_AREA_LENGTH);

    always_comb
    begin
        area_length_next = area_length_reg;
        if (wr_en)
        begin
            area_length_next = pwdata[ebid_pkg::LEN_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_length_reg <= '0;
        end
        else
        begin
            area_length_reg <= area_length_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ebid_pkg::ADDR_AREA_LENGTH)
        begin
            prdata = {{(32 - ebid_pkg::LEN_BITS){1'b0}}, area_length_reg};
        end
    end

    assign area_length = area_length_reg;

endmodule
`default_nettype wire

@@ rtl/ebid_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ebid_core
// Per-byte note walker: header capture, name check, descriptor emission.
// ----------------------------------------------------------------------------
module ebid_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [7:0]      area_byte,
    input  wire logic            area_end,
    input  ebid_pkg::len_t       area_length,
    output logic                 res_valid,
    output ebid_pkg::result_t    res
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_NAME   = 3'd1;
    localparam logic [2:0] PH_DESC   = 3'd2;
    localparam logic [2:0] PH_SKIP   = 3'd3;

    ebid_pkg::pos_t pos_reg, pos_next;
    ebid_pkg::pos_t start_reg, start_next;
    logic [2:0]     phase_reg, phase_next;
    logic [31:0]    name_size_reg, name_size_next;
    logic [31:0]    desc_size_reg, desc_size_next;
    logic [31:0]    kind_reg, kind_next;
    logic           match_reg, match_next;
    logic           done_reg, done_next;

    ebid_pkg::pos_t rel;
    ebid_pkg::pos_t nrel;
    ebid_pkg::wide_t len_w, pos1_w, name_end_w, next_w;
    logic [31:0]    lane_mask, lane_byte;
    logic [31:0]    kind_mrg;
    logic           do_leave, do_boundary;
    logic           emit, fin;
    logic [1:0]     status;
    logic [7:0]     idb;

    assign rel        = pos_reg - start_reg;
    assign nrel       = rel - ebid_pkg::pos_t'(ebid_pkg::HDR_BYTES);
    assign len_w      = ebid_pkg::wide_t'(area_length);
    assign pos1_w     = ebid_pkg::wide_t'(pos_reg) + ebid_pkg::wide_t'(1);
    assign name_end_w = ebid_pkg::wide_t'(start_reg) + ebid_pkg::wide_t'(ebid_pkg::HDR_BYTES)
                        + ebid_pkg::pad4(name_size_reg);
    assign next_w     = name_end_w + ebid_pkg::pad4(desc_size_reg);
    assign lane_mask  = 32'hFF << {rel[1:0], 3'b000};
    assign lane_byte  = {24'd0, area_byte} << {rel[1:0], 3'b000};
    assign kind_mrg   = (rel[3:2] == 2'd2) ? ((kind_reg & ~lane_mask) | lane_byte) : kind_reg;

    always_comb
    begin
        pos_next       = pos_reg;
        start_next     = start_reg;
        phase_next     = phase_reg;
        name_size_next = name_size_reg;
        desc_size_next = desc_size_reg;
        kind_next      = kind_reg;
        match_next     = match_reg;
        done_next      = done_reg;
        emit           = 1'b0;
        fin            = 1'b0;
        status         = ebid_pkg::ST_FOUND;
        idb            = 8'd0;
        do_leave       = 1'b0;
        do_boundary    = 1'b0;

        if (!done_reg)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (rel == '0 && (ebid_pkg::wide_t'(start_reg)
                            + ebid_pkg::wide_t'(ebid_pkg::HDR_BYTES) > len_w))
                    begin
                        fin    = 1'b1;
                        status = ebid_pkg::ST_NOT_FOUND;
                    end
                    else if (rel < ebid_pkg::pos_t'(ebid_pkg::HDR_BYTES))
                    begin
                        unique case (rel[3:2])
                            2'd0:    name_size_next = (name_size_reg & ~lane_mask) | lane_byte;
                            2'd1:    desc_size_next = (desc_size_reg & ~lane_mask) | lane_byte;
                            default: kind_next      = kind_mrg;
                        endcase
                        if (rel == ebid_pkg::pos_t'(ebid_pkg::HDR_BYTES - 1))
                        begin
                            // The padded name end already covers the name size and
                            // header checks, so one sum decides an overrun.
                            if (name_end_w + ebid_pkg::wide_t'(desc_size_reg) > len_w)
                            begin
                                fin    = 1'b1;
                                status = ebid_pkg::ST_MALFORMED;
                            end
                            else if (kind_mrg == ebid_pkg::BUILD_ID_TYPE
                                     && name_size_reg >= ebid_pkg::MIN_NAME_SIZE)
                            begin
                                match_next = 1'b1;
                                phase_next = PH_NAME;
                            end
                            else
                            begin
                                do_leave = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        fin    = 1'b1;
                        status = ebid_pkg::ST_MALFORMED;
                    end
                end
                PH_NAME:
                begin
                    if (rel >= ebid_pkg::pos_t'(ebid_pkg::HDR_BYTES) && nrel < ebid_pkg::pos_t'(3)
                        && area_byte != ebid_pkg::gnu_tag(nrel[1:0]))
                    begin
                        match_next = 1'b0;
                    end
                    if (pos1_w == name_end_w)
                    begin
                        if (!match_next)
                        begin
                            do_leave = 1'b1;
                        end
                        else if (desc_size_reg == 32'd0)
                        begin
                            fin    = 1'b1;
                            status = ebid_pkg::ST_FOUND;
                        end
                        else
                        begin
                            phase_next = PH_DESC;
                        end
                    end
                end
                PH_DESC:
                begin
                    emit = 1'b1;
                    idb  = area_byte;
                    if (pos1_w == name_end_w + ebid_pkg::wide_t'(desc_size_reg))
                    begin
                        fin    = 1'b1;
                        status = ebid_pkg::ST_FOUND;
                    end
                end
                default:
                begin
                    if (pos1_w == next_w)
                    begin
                        do_boundary = 1'b1;
                    end
                end
            endcase

            if (do_leave)
            begin
                if (next_w > len_w)
                begin
                    fin    = 1'b1;
                    status = ebid_pkg::ST_MALFORMED;
                end
                else if (next_w == pos1_w)
                begin
                    do_boundary = 1'b1;
                end
                else
                begin
                    phase_next = PH_SKIP;
                end
            end

            if (do_boundary)
            begin
                if (next_w + ebid_pkg::wide_t'(ebid_pkg::HDR_BYTES) > len_w)
                begin
                    fin    = 1'b1;
                    status = ebid_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    start_next = next_w[ebid_pkg::POSITION_BITS-1:0];
                    phase_next = PH_HEADER;
                end
            end

            if (fin)
            begin
                done_next = 1'b1;
            end
            pos_next = pos_reg + ebid_pkg::pos_t'(1);
        end

        if (area_end)
        begin
            if (!done_next)
            begin
                fin    = 1'b1;
                status = ebid_pkg::ST_MALFORMED;
            end
            pos_next       = '0;
            start_next     = '0;
            phase_next     = PH_HEADER;
            name_size_next = '0;
            desc_size_next = '0;
            kind_next      = '0;
            match_next     = 1'b1;
            done_next      = 1'b0;
        end
    end

    assign res_valid         = step && (emit || fin);
    assign res.id_byte       = idb;
    assign res.id_byte_valid = emit;
    assign res.finished      = fin;
    assign res.scan_status   = fin ? status : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            start_reg     <= '0;
            phase_reg     <= PH_HEADER;
            name_size_reg <= '0;
            desc_size_reg <= '0;
            kind_reg      <= '0;
            match_reg     <= 1'b1;
            done_reg      <= 1'b0;
        end
        else if (step)
        begin
            pos_reg       <= pos_next;
            start_reg     <= start_next;
            phase_reg     <= phase_next;
            name_size_reg <= name_size_next;
            desc_size_reg <= desc_size_next;
            kind_reg      <= kind_next;
            match_reg     <= match_next;
            done_reg      <= done_next;
        end
    end

    // The end of an area always returns the walker to the start of a fresh scan.
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && area_end |=> pos_reg == '0 && !done_reg && phase_reg == PH_HEADER)
        else $error("area end did not clear the scan state");

    // A finished scan does not move its position again until the end of its area.
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step && done_reg && !area_end |=> done_reg && $stable(pos_reg))
        else $error("finished scan kept advancing");

endmodule
`default_nettype wire

@@ rtl/ebid_outbuf.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ebid_outbuf
// Result register with a skid entry, so input keeps flowing under a stall.
// ----------------------------------------------------------------------------
module ebid_outbuf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  ebid_pkg::result_t      push_word,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ebid_pkg::result_t      out_word
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    ebid_pkg::result_t main_reg, main_next;
    ebid_pkg::result_t skid_reg, skid_next;
    logic              pop;

    assign pop       = main_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_word  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_next       = push_word;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_next       = push_word;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_word;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    // The skid entry only fills behind a held result.
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry valid with an empty result register");

    // Nothing is pushed while both entries are occupied.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("result pushed into a full buffer");

endmodule
`default_nettype wire

@@ rtl/elf_build_id_note_scanner.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// elf_build_id_note_scanner
// Streams an ELF note area byte by byte and returns the GNU build id bytes.
// ----------------------------------------------------------------------------
// Write area_length before streaming each note area. One byte word is taken
// every clock cycle while input ready is high; each byte is decided by the
// note walker in the same cycle it is accepted (a handful of adds and compares
// on the header sizes); a result enters the output buffer on the next cycle.
// A two-entry output buffer lets the input keep running for one more
// result while the sink stalls; input ready drops only when both entries
// are full. Descriptor bytes of the first GNU build-id note come out with
// id_byte_valid set, and the last word of a scan carries finished and its
// status. Bytes after the status are swallowed until area_end.
module elf_build_id_note_scanner (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    ebid_in_if.sink                              in_ch,
    ebid_out_if.source                           out_ch,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ebid_pkg::PADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready
);

    ebid_pkg::len_t    area_length;
    ebid_pkg::result_t core_res;
    ebid_pkg::result_t out_word;
    logic              core_res_valid;
    logic              in_ready;
    logic              step;

    assign in_ch.ready = in_ready;
    assign step        = in_ch.valid && in_ready;

    ebid_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .area_length (area_length)
    );

    ebid_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .area_byte   (in_ch.area_byte),
        .area_end    (in_ch.area_end),
        .area_length (area_length),
        .res_valid   (core_res_valid),
        .res         (core_res)
    );

    ebid_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (core_res_valid),
        .push_word (core_res),
        .in_ready  (in_ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_word  (out_word)
    );

    assign out_ch.id_byte       = out_word.id_byte;
    assign out_ch.id_byte_valid = out_word.id_byte_valid;
    assign out_ch.finished      = out_word.finished;
    assign out_ch.scan_status   = out_word.scan_status;

endmodule
`default_nettype wire
